[hdl/priority_task_queue_macros.svh]
// ----------------------------------------------------------------------------
// priority_task_queue_macros
// Assertion macros shared by the priority task queue RTL.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_TASK_QUEUE_MACROS_SVH
`define PRIORITY_TASK_QUEUE_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define PTQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next
`define PTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ptq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptq_pkg
// Types and constants of the priority task queue.
// ----------------------------------------------------------------------------
package ptq_pkg;

  localparam int PRIO_W = 16;
  localparam int TAG_W  = 16;
  localparam int ARR_W  = 16;
  localparam int IN_W   = 40;   // 1 + 16 + 16 bits, padded to whole bytes

  // Command codes
  localparam logic CMD_SUBMIT   = 1'b0;
  localparam logic CMD_DISPATCH = 1'b1;

  // One stored task
  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic        [TAG_W-1:0]  tag;
    logic        [ARR_W-1:0]  arrival;
  } ptq_entry_t;

  // Chain-wide operation of the current cycle
  typedef struct packed {
    logic push;   // insert a new entry in order
    logic pop;    // remove the head, shift towards the head
  } ptq_ctrl_t;

endpackage

[hdl/ptq_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptq_cell
// One slot of the sorted chain: holds an entry and trades with neighbours.
// ----------------------------------------------------------------------------
module ptq_cell
  import ptq_pkg::*;
(
  input  logic       clk,
  input  ptq_ctrl_t  ctrl,
  input  logic       valid,        // slot holds a live entry
  input  ptq_entry_t new_entry,
  input  logic       left_ahead,   // new entry lands at or before the left slot
  input  ptq_entry_t left_entry,
  input  ptq_entry_t right_entry,
  output logic       ahead,        // new entry lands at or before this slot
  output ptq_entry_t entry
);

  ptq_entry_t entry_r;
  ptq_entry_t entry_nxt;

  // New entry goes ahead of an empty slot or a strictly lower priority
  assign ahead = !valid || (new_entry.prio > entry_r.prio);

  // Take from the left, take the new entry, or take from the right
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.push) begin
      if (left_ahead) begin
        entry_nxt = left_entry;
      end else if (ahead) begin
        entry_nxt = new_entry;
      end
    end else if (ctrl.pop) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

[hdl/priority_task_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_task_queue
// Bounded priority queue with first-in-first-out order among equal priorities.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream in_*: each transfer is a submit (priority and tag) or a
//   dispatch. Every transfer yields exactly one result on out_*: accepted,
//   found, the dispatched tag and the occupancy after the step.
//   A submit to a full queue is dropped with accepted low; a dispatch on an
//   empty queue returns found low and a zero tag.
//   The result appears in the output register on the cycle after the input
//   transfer. One item per cycle is sustained while the receiver does not
//   stall, since each slot of the sorted chain makes its insert or shift
//   decision combinationally from its own and its neighbours' contents.
//   When the receiver stalls, the result is held and in_tready drops until
//   it is taken; a new input may transfer in the same cycle the held result
//   leaves.
//   Reset clears the occupancy, the arrival stamp and the output valid;
//   slot contents are left as they are and never read while empty.
// ----------------------------------------------------------------------------
`include "priority_task_queue_macros.svh"

module priority_task_queue
  import ptq_pkg::*;
#(
  parameter  int DEPTH = 16,
  localparam int CW    = $clog2(DEPTH + 1),
  localparam int OUT_W = ((2 + TAG_W + CW + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  // input: command [0], priority_req [16:1], tag [32:17]
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             in_tvalid,
  output logic             in_tready,
  // output: accepted [0], found [1], out_tag [17:2], occupancy [17+CW:18]
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_tvalid,
  input  logic             out_tready
);

  logic                     in_cmd;
  logic signed [PRIO_W-1:0] in_prio;
  logic        [TAG_W-1:0]  in_tag;
  logic                     in_xfer;

  logic [CW-1:0]    count_r, count_nxt;
  logic [ARR_W-1:0] arrival_r, arrival_nxt;
  logic             full, empty;
  ptq_ctrl_t        ctrl;
  ptq_entry_t       new_entry;

  ptq_entry_t       cell_entry [DEPTH];
  logic             cell_ahead [DEPTH];

  logic [OUT_W-1:0] out_tdata_r, out_tdata_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;
  logic             res_accepted, res_found;
  logic [TAG_W-1:0] res_tag;

  // Unpack the input transfer
  assign in_cmd  = in_tdata[0];
  assign in_prio = in_tdata[PRIO_W:1];
  assign in_tag  = in_tdata[PRIO_W+TAG_W:PRIO_W+1];

  assign in_tready = !out_tvalid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  // Decide the chain operation
  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign ctrl.push = in_xfer && (in_cmd == CMD_SUBMIT) && !full;
  assign ctrl.pop  = in_xfer && (in_cmd == CMD_DISPATCH) && !empty;
  assign new_entry = '{prio: in_prio, tag: in_tag, arrival: arrival_r};

  // Sorted chain, head at slot 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic       left_ahead;
    ptq_entry_t left_entry;
    ptq_entry_t right_entry;

    if (i == 0) begin : g_head
      assign left_ahead = 1'b0;
      assign left_entry = '0;
    end else begin : g_mid
      assign left_ahead = cell_ahead[i-1];
      assign left_entry = cell_entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_entry = '0;
    end else begin : g_body
      assign right_entry = cell_entry[i+1];
    end

    ptq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .valid       (count_r > CW'(i)),
      .new_entry   (new_entry),
      .left_ahead  (left_ahead),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .ahead       (cell_ahead[i]),
      .entry       (cell_entry[i])
    );
  end

  // Advance occupancy and arrival stamp
  always_comb begin
    count_nxt   = count_r;
    arrival_nxt = arrival_r;
    if (ctrl.push) begin
      count_nxt   = count_r + 1'b1;
      arrival_nxt = arrival_r + 1'b1;
    end else if (ctrl.pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Build the result; hold it while the receiver stalls
  assign res_accepted = ctrl.push;
  assign res_found    = ctrl.pop;
  assign res_tag      = ctrl.pop ? cell_entry[0].tag : '0;

  always_comb begin
    out_tdata_nxt  = out_tdata_r;
    out_tvalid_nxt = out_tvalid_r;
    if (in_xfer) begin
      out_tdata_nxt  = OUT_W'({count_nxt, res_tag, res_found, res_accepted});
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      arrival_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      arrival_r    <= arrival_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tdata  = out_tdata_r;
  assign out_tvalid = out_tvalid_r;

  // Checks
  `PTQ_ASSERT(a_count_bound, count_r <= CW'(DEPTH), "occupancy above depth")
  `PTQ_ASSERT(a_head_order, (count_r < CW'(2)) || (cell_entry[0].prio >= cell_entry[1].prio), "head slots out of order")
  `PTQ_ASSERT_NEXT(a_push_count, ctrl.push, count_r == $past(count_r) + 1'b1, "submit did not grow the queue")
  `PTQ_ASSERT_NEXT(a_pop_tag, ctrl.pop, out_tdata_r[TAG_W+1:2] == $past(cell_entry[0].tag), "dispatch did not return the head tag")

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the priority task queue.
// ----------------------------------------------------------------------------
// Submits and dispatches stream in through in_*. Each accepted transfer is
// run through a local sorted-chain model of the queue. The model gives the
// result that out_* must return for it, and the result is checked field by
// field. Directed tests cover field extremes, first-in-first-out order among
// equal priorities, dispatch on an empty queue and submit to a full one. A
// long receiver stall checks that the block holds its result and blocks its
// input. Random traffic in phases then fills and drains the queue, with
// bursty sending and varied receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import ptq_pkg::*;

  localparam int DEPTH        = 16;
  localparam int CW           = $clog2(DEPTH + 1);
  localparam int OUT_W        = ((2 + TAG_W + CW + 7) / 8) * 8;
  localparam int PAD_W        = IN_W - 1 - PRIO_W - TAG_W;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 200;
  localparam int RANDOM_ITEMS = 1800;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  typedef struct {
    logic             accepted;
    logic             found;
    logic [TAG_W-1:0] tag;
    logic [CW-1:0]    occupancy;
  } task_result_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic [IN_W-1:0]  in_tdata   = '0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tvalid;
  logic             out_tready = 1'b0;

  // Local copy of the sorted chain, position 0 served first
  logic signed [PRIO_W-1:0] chain_prio [DEPTH];
  logic        [TAG_W-1:0]  chain_tag  [DEPTH];
  int                       chain_count = 0;

  task_result_t due_results [$];

  int       errors         = 0;
  int       results_seen   = 0;
  int       items_sent     = 0;
  int       n_stored       = 0;
  int       n_dropped      = 0;
  int       n_served       = 0;
  int       n_empty        = 0;
  int       burst_left     = 0;
  int       hold_left      = 0;
  int       idle_cycles    = 0;
  rx_mode_t rx_mode        = RX_ALWAYS;
  logic [7:0] rx_pattern   = 8'b1011_0110;

  priority_task_queue #(.DEPTH(DEPTH)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  always #10 clk = ~clk;

  // Advance the local chain by one command and return the result it yields
  function automatic task_result_t queue_step(input logic cmd,
                                              input logic signed [PRIO_W-1:0] prio,
                                              input logic [TAG_W-1:0] tag);
    task_result_t r;
    int pos;
    r = '{1'b0, 1'b0, '0, '0};
    if (cmd == CMD_SUBMIT) begin
      if (chain_count < DEPTH) begin
        pos = 0;
        while (pos < chain_count && chain_prio[pos] >= prio) pos++;
        for (int i = chain_count; i > pos; i--) begin
          chain_prio[i] = chain_prio[i-1];
          chain_tag[i]  = chain_tag[i-1];
        end
        chain_prio[pos] = prio;
        chain_tag[pos]  = tag;
        chain_count++;
        r.accepted = 1'b1;
        n_stored++;
      end else begin
        n_dropped++;
      end
    end else begin
      if (chain_count > 0) begin
        r.found = 1'b1;
        r.tag   = chain_tag[0];
        for (int i = 0; i + 1 < chain_count; i++) begin
          chain_prio[i] = chain_prio[i+1];
          chain_tag[i]  = chain_tag[i+1];
        end
        chain_count--;
        n_served++;
      end else begin
        n_empty++;
      end
    end
    r.occupancy = chain_count[CW-1:0];
    return r;
  endfunction

  // Priority drawn in one of three styles: tie-heavy, full range, extremes
  function automatic logic signed [PRIO_W-1:0] pick_priority(input int style);
    logic signed [PRIO_W-1:0] p;
    case (style)
      0: p = PRIO_W'($urandom_range(0, 3)) - 16'sd1;
      1: p = PRIO_W'($urandom);
      default: begin
        case ($urandom_range(0, 4))
          0: p = 16'sh7FFF;
          1: p = 16'sh8000;
          2: p = 16'sh0000;
          3: p = 16'shFFFF;
          default: p = PRIO_W'($urandom);
        endcase
      end
    endcase
    return p;
  endfunction

  // Offer one item in bursts with random gaps; predict on transfer
  task automatic send_item(input logic cmd,
                           input logic signed [PRIO_W-1:0] prio,
                           input logic [TAG_W-1:0] tag);
    int gap;
    task_result_t pred;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tdata  = {{PAD_W{1'b0}}, tag, prio, cmd};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    pred = queue_step(cmd, prio, tag);
    due_results = {due_results, pred};
    items_sent++;
    @(negedge clk);
  endtask

  // Dispatch on an empty queue, with the unused fields set
  task automatic test_empty_dispatch;
    send_item(CMD_DISPATCH, 16'sh7FFF, 16'hFFFF);
    send_item(CMD_DISPATCH, 16'sh8000, 16'h0000);
  endtask

  // Priority and tag extremes mixed with equal priorities, then dispatch past empty
  task automatic test_order_extremes;
    send_item(CMD_SUBMIT, 16'sh8000, 16'hFFFF);
    send_item(CMD_SUBMIT, 16'sh7FFF, 16'h0000);
    send_item(CMD_SUBMIT, 16'sh0005, 16'hAAAA);
    send_item(CMD_SUBMIT, 16'shFFFF, 16'h1234);
    send_item(CMD_SUBMIT, 16'sh0005, 16'h5555);
    send_item(CMD_SUBMIT, 16'sh0005, 16'h00F0);
    repeat (7) send_item(CMD_DISPATCH, PRIO_W'($urandom), TAG_W'($urandom));
  endtask

  // Fill past the limit so the excess is dropped, then drain past empty
  task automatic test_fill_overflow;
    repeat (DEPTH + 2) send_item(CMD_SUBMIT, pick_priority(0), TAG_W'($urandom));
    repeat (DEPTH + 1) send_item(CMD_DISPATCH, pick_priority(1), TAG_W'($urandom));
  endtask

  // Stall the receiver for a long stretch while items keep coming
  task automatic test_held_output;
    rx_mode    = RX_ALWAYS;
    hold_left  = HOLD_CYCLES;
    burst_left = 40;
    repeat (20) send_item(CMD_SUBMIT, pick_priority(2), TAG_W'($urandom));
    repeat (20) send_item(CMD_DISPATCH, pick_priority(1), TAG_W'($urandom));
  endtask

  // Phases of random traffic, biased to fill, to drain or to hover
  task automatic test_random_traffic;
    int sent;
    int phase_len;
    int submit_pct;
    int style;
    logic cmd;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(40, 160);
      case ($urandom_range(0, 2))
        0: submit_pct = 25;
        1: submit_pct = 50;
        default: submit_pct = 75;
      endcase
      style   = $urandom_range(0, 2);
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      repeat (phase_len) begin
        cmd = ($urandom_range(0, 99) < submit_pct) ? CMD_SUBMIT : CMD_DISPATCH;
        send_item(cmd, pick_priority(style), TAG_W'($urandom));
        sent++;
      end
    end
  endtask

  // Receiver: long hold-off when asked, otherwise the current stall style
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  = hold_left - 1;
    end else begin
      case (rx_mode)
        RX_ALWAYS: out_tready <= 1'b1;
        RX_RANDOM: out_tready <= ($urandom_range(0, 99) >= 35);
        default: begin
          out_tready <= rx_pattern[0];
          rx_pattern <= {rx_pattern[0], rx_pattern[7:1]};
        end
      endcase
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin : check_results
    task_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (due_results.size() == 0) begin
        $error("unexpected result transfer: tdata %h", out_tdata);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (out_tdata[0] !== want.accepted) begin
          $error("accepted: expected %0b, got %0b", want.accepted, out_tdata[0]);
          errors++;
        end
        if (out_tdata[1] !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, out_tdata[1]);
          errors++;
        end
        if (out_tdata[2 +: TAG_W] !== want.tag) begin
          $error("out_tag: expected %h, got %h", want.tag, out_tdata[2 +: TAG_W]);
          errors++;
        end
        if (out_tdata[2 + TAG_W +: CW] !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d",
                 want.occupancy, out_tdata[2 + TAG_W +: CW]);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing transfers for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_dispatch();
    test_order_extremes();
    test_fill_overflow();
    test_held_output();
    test_random_traffic();

    // Drain and allow for the output register
    in_tvalid = 1'b0;
    rx_mode   = RX_ALWAYS;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("tb_top: %0d items sent, %0d results checked, %0d errors",
             items_sent, results_seen, errors);
    $display("tb_top: stored %0d, dropped when full %0d, served %0d, empty %0d",
             n_stored, n_dropped, n_served, n_empty);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

[priority_task_queue.f]
+incdir+hdl
hdl/ptq_pkg.sv
hdl/ptq_cell.sv
hdl/priority_task_queue.sv
tb/tb_top.sv
